// ===== hw/rtl/bicubic_bezier_point_evaluator_assert.svh =====
// Assertion macros used by the bicubic Bezier point evaluator controller.
`ifndef BICUBIC_BEZIER_POINT_EVALUATOR_ASSERT_SVH
`define BICUBIC_BEZIER_POINT_EVALUATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define BBPE_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bbpe: same-cycle check failed");
`define BBPE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bbpe: next-cycle check failed");
`else
`define BBPE_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define BBPE_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/bbpe_pkg.sv =====
// Types, constants and control structs of the bicubic Bezier point evaluator.
package bbpe_pkg;

  localparam int COORD_W   = 32;
  localparam int PARAM_W   = 17;
  localparam int NORM_W    = 16;
  localparam int NUM_CP    = 16;
  localparam int IDX_W     = $clog2(NUM_CP);
  localparam int NUM_AXES  = 3;
  localparam int WGT_W     = 28;
  localparam int WFRAC     = 57 - COORD_W;
  localparam int WGT_CYC   = 2;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS = 15;
  localparam int CNT_W     = 5;

  localparam logic [PARAM_W-1:0] ONE_Q16 = PARAM_W'(65536);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  typedef logic signed [WGT_W-1:0] wgt_t;

  typedef struct packed {
    logic                      op;
    logic [IDX_W-1:0]          cp_index;
    logic signed [COORD_W-1:0] cp_x;
    logic signed [COORD_W-1:0] cp_y;
    logic signed [COORD_W-1:0] cp_z;
    logic [PARAM_W-1:0]        param_u;
    logic [PARAM_W-1:0]        param_v;
  } item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic signed [NORM_W-1:0]  norm_x;
    logic signed [NORM_W-1:0]  norm_y;
    logic signed [NORM_W-1:0]  norm_z;
    logic                      degenerate;
  } result_t;

  typedef struct packed {
    logic             wr;
    logic             capture;
    logic             rd;
    logic [IDX_W-1:0] rd_addr;
    logic             fin;
    logic             rmax;
    logic             rshift;
    logic             xmul;
    logic             xsub;
    logic             ninit;
    logic             nstep;
    logic             sq;
    logic             sqrt_init;
    logic             sqrt_step;
    logic             div_init;
    logic             div_step;
    logic             div_store;
    logic [1:0]       lane;
    logic             out_load;
  } cmd_t;

  typedef struct packed {
    logic acc_done;
    logic degenerate;
    logic norm_done;
  } status_t;

endpackage

// ===== hw/rtl/bbpe_weights.sv =====
// Two-stage Bernstein and derivative weight generator for one patch parameter.
module bbpe_weights (
  input  logic                         clk,
  input  logic [bbpe_pkg::PARAM_W-1:0] param,
  output bbpe_pkg::wgt_t [3:0]         b,
  output bbpe_pkg::wgt_t [3:0]         d
);
  import bbpe_pkg::*;

  localparam int SQ_W = 2 * PARAM_W;
  localparam int CB_W = 3 * PARAM_W;
  localparam int X_W  = SQ_W + 2;
  localparam int B_SH = 48 - WFRAC;
  localparam int D_SH = B_SH - 16;

  logic [PARAM_W-1:0]    s0;
  logic [PARAM_W-1:0]    s1;
  logic [SQ_W-1:0]       ss;
  logic [SQ_W-1:0]       ts;
  logic [SQ_W-1:0]       tt;
  logic [PARAM_W-1:0]    t1;
  logic [CB_W-1:0]       cb [4];
  logic signed [X_W-1:0] xd [4];

  function automatic wgt_t rnd_cube(input logic [CB_W-1:0] x);
    logic [CB_W-1:0] r;
    r = (x + (CB_W'(1) << (B_SH - 1))) >> B_SH;
    return WGT_W'(r);
  endfunction

  // Derivative products carry one factor of 2^16 fewer than the cubes, so fewer bits drop.
  function automatic wgt_t rnd_der(input logic signed [X_W-1:0] x);
    logic [X_W-1:0] mag;
    logic [X_W-1:0] m;
    mag = x[X_W-1] ? X_W'(-x) : X_W'(x);
    m   = (mag + (X_W'(1) << (D_SH - 1))) >> D_SH;
    return x[X_W-1] ? WGT_W'(-m) : WGT_W'(m);
  endfunction

  assign s0 = ONE_Q16 - param;

  always_comb begin
    cb[0] = CB_W'(ss) * CB_W'(s1);
    cb[1] = CB_W'(3) * CB_W'(ts) * CB_W'(s1);
    cb[2] = CB_W'(3) * CB_W'(tt) * CB_W'(s1);
    cb[3] = CB_W'(tt) * CB_W'(t1);
    xd[0] = -$signed(X_W'(3) * X_W'(ss));
    xd[1] = $signed(X_W'(3) * X_W'(ss)) - $signed(X_W'(6) * X_W'(ts));
    xd[2] = $signed(X_W'(6) * X_W'(ts)) - $signed(X_W'(3) * X_W'(tt));
    xd[3] = $signed(X_W'(3) * X_W'(tt));
  end

  always_ff @(posedge clk) begin
    t1 <= param;
    s1 <= s0;
    ss <= SQ_W'(s0) * SQ_W'(s0);
    ts <= SQ_W'(param) * SQ_W'(s0);
    tt <= SQ_W'(param) * SQ_W'(param);
    for (int k = 0; k < 4; k++) begin
      b[k] <= rnd_cube(cb[k]);
      d[k] <= rnd_der(xd[k]);
    end
  end

endmodule

// ===== hw/rtl/bbpe_datapath.sv =====
// Datapath: control point store, patch accumulation, normal and shared divider.
module bbpe_datapath (
  input  logic              clk,
  input  logic              rst,
  input  bbpe_pkg::item_t   item,
  input  bbpe_pkg::cmd_t    cmd,
  output bbpe_pkg::status_t st,
  output bbpe_pkg::result_t result
);
  import bbpe_pkg::*;

  localparam int PROD_W = 64;
  localparam int ROW_W  = 38;
  localparam int DER_W  = 40;
  localparam int RED_W  = 32;
  localparam int CM_W   = 63;
  localparam int SQ_W   = 60;
  localparam int LEN_W  = 32;
  localparam int Q_W    = DIV_STEPS;
  localparam int NUM_W  = 46;

  localparam logic [DER_W-1:0] LIM30 = DER_W'(1) << 30;
  localparam logic [CM_W-1:0]  M38   = CM_W'(1) << 38;
  localparam logic [CM_W-1:0]  M30   = CM_W'(1) << 30;
  localparam logic [CM_W-1:0]  M29   = CM_W'(1) << 29;
  localparam logic [CM_W-1:0]  M21   = CM_W'(1) << 21;

  logic signed [COORD_W-1:0] mem_x [NUM_CP];
  logic signed [COORD_W-1:0] mem_y [NUM_CP];
  logic signed [COORD_W-1:0] mem_z [NUM_CP];
  logic signed [COORD_W-1:0] rd_q  [NUM_AXES];

  logic [PARAM_W-1:0] u_q;
  logic [PARAM_W-1:0] v_q;
  wgt_t [3:0] bu;
  wgt_t [3:0] duw;
  wgt_t [3:0] bv;
  wgt_t [3:0] dvw;

  logic       v1, v2, last3, v4, v5, acc_done;
  logic [1:0] col1, row1, col2, row2, row3, row4;
  logic       first5, last5;

  logic signed [PROD_W-1:0] pb      [NUM_AXES];
  logic signed [PROD_W-1:0] pd      [NUM_AXES];
  logic signed [PROD_W-1:0] rsb     [NUM_AXES];
  logic signed [PROD_W-1:0] rsd     [NUM_AXES];
  logic signed [ROW_W-1:0]  rowb    [NUM_AXES];
  logic signed [ROW_W-1:0]  rowd    [NUM_AXES];
  logic signed [PROD_W-1:0] mpos    [NUM_AXES];
  logic signed [PROD_W-1:0] mdu     [NUM_AXES];
  logic signed [PROD_W-1:0] mdv     [NUM_AXES];
  logic signed [PROD_W-1:0] acc_pos [NUM_AXES];
  logic signed [PROD_W-1:0] acc_du  [NUM_AXES];
  logic signed [PROD_W-1:0] acc_dv  [NUM_AXES];

  logic signed [COORD_W-1:0] pos_r [NUM_AXES];
  logic signed [DER_W-1:0]   du    [NUM_AXES];
  logic signed [DER_W-1:0]   dv    [NUM_AXES];
  logic [2:0]                kdu;
  logic [2:0]                kdv;
  logic signed [RED_W-1:0]   dur   [NUM_AXES];
  logic signed [RED_W-1:0]   dvr   [NUM_AXES];
  logic signed [PROD_W-1:0]  xp    [6];
  logic signed [PROD_W-1:0]  cr    [NUM_AXES];
  logic [CM_W-1:0]           cm    [NUM_AXES];
  logic                      neg   [NUM_AXES];
  logic                      degen;
  logic [CM_W-1:0]           cm_max;
  logic [SQ_W-1:0]           sq    [NUM_AXES];

  logic [PROD_W-1:0] sq_n;
  logic [PROD_W-1:0] sq_res;
  logic [PROD_W-1:0] sq_bit;
  logic [PROD_W-1:0] sq_try;
  logic [LEN_W-1:0]  len;

  logic [NUM_W-1:0]         num;
  logic [LEN_W-1:0]         rem;
  logic [LEN_W:0]           rem2;
  logic [Q_W-1:0]           nsh;
  logic [Q_W-1:0]           quo;
  logic signed [NORM_W-1:0] nrm [NUM_AXES];

  function automatic logic signed [PROD_W-1:0] rnd_frac(input logic signed [PROD_W-1:0] x);
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] m;
    mag = x[PROD_W-1] ? PROD_W'(-x) : PROD_W'(x);
    m   = (mag + (PROD_W'(1) << (WFRAC - 1))) >> WFRAC;
    return x[PROD_W-1] ? $signed(-m) : $signed(m);
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [PROD_W-1:0] x);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = PROD_W'((PROD_W'(1) << (COORD_W - 1)) - PROD_W'(1));
    lo = -hi - PROD_W'(1);
    if (x > hi) begin
      return COORD_W'(hi);
    end else if (x < lo) begin
      return COORD_W'(lo);
    end
    return COORD_W'(x);
  endfunction

  function automatic logic [DER_W-1:0] mag_der(input logic signed [DER_W-1:0] x);
    return x[DER_W-1] ? DER_W'(-x) : DER_W'(x);
  endfunction

  // Smallest right shift that brings the largest component to 2^30 or below.
  function automatic logic [2:0] shift_k(input logic signed [DER_W-1:0] a,
                                         input logic signed [DER_W-1:0] b,
                                         input logic signed [DER_W-1:0] c);
    logic [DER_W-1:0] mx;
    logic [2:0]       k;
    mx = mag_der(a);
    if (mag_der(b) > mx) begin
      mx = mag_der(b);
    end
    if (mag_der(c) > mx) begin
      mx = mag_der(c);
    end
    k = 3'd7;
    for (int i = 7; i >= 0; i--) begin
      if ((mx >> i) <= LIM30) begin
        k = 3'(i);
      end
    end
    return k;
  endfunction

  function automatic logic signed [RED_W-1:0] rsh(input logic signed [DER_W-1:0] x,
                                                  input logic [2:0] k);
    logic [DER_W-1:0] mag;
    logic [DER_W-1:0] half;
    logic [DER_W-1:0] m;
    mag  = mag_der(x);
    half = (k == 3'd0) ? '0 : (DER_W'(1) << (k - 3'd1));
    m    = (mag + half) >> k;
    return x[DER_W-1] ? RED_W'(-m) : RED_W'(m);
  endfunction

  bbpe_weights u_wgt_u (.clk(clk), .param(u_q), .b(bu), .d(duw));
  bbpe_weights u_wgt_v (.clk(clk), .param(v_q), .b(bv), .d(dvw));

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem_x[item.cp_index] <= item.cp_x;
      mem_y[item.cp_index] <= item.cp_y;
      mem_z[item.cp_index] <= item.cp_z;
    end
    if (cmd.rd) begin
      rd_q[0] <= mem_x[cmd.rd_addr];
      rd_q[1] <= mem_y[cmd.rd_addr];
      rd_q[2] <= mem_z[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      u_q <= (item.param_u > ONE_Q16) ? ONE_Q16 : item.param_u;
      v_q <= (item.param_v > ONE_Q16) ? ONE_Q16 : item.param_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      last3    <= 1'b0;
      v4       <= 1'b0;
      v5       <= 1'b0;
      acc_done <= 1'b0;
    end else begin
      v1       <= cmd.rd;
      v2       <= v1;
      last3    <= v2 && (col2 == 2'd3);
      v4       <= last3;
      v5       <= v4;
      acc_done <= v5 && last5;
    end
  end

  // Accumulation pipeline: read, weight along v, row sum, round, weight along u, sum.
  always_ff @(posedge clk) begin
    col1   <= cmd.rd_addr[1:0];
    row1   <= cmd.rd_addr[IDX_W-1:2];
    col2   <= col1;
    row2   <= row1;
    row3   <= row2;
    row4   <= row3;
    first5 <= (row4 == 2'd0);
    last5  <= (row4 == 2'd3);
    for (int c = 0; c < NUM_AXES; c++) begin
      pb[c] <= PROD_W'(rd_q[c]) * PROD_W'(bv[col1]);
      pd[c] <= PROD_W'(rd_q[c]) * PROD_W'(dvw[col1]);
      if (v2) begin
        rsb[c] <= (col2 == 2'd0) ? pb[c] : rsb[c] + pb[c];
        rsd[c] <= (col2 == 2'd0) ? pd[c] : rsd[c] + pd[c];
      end
      if (last3) begin
        rowb[c] <= ROW_W'(rnd_frac(rsb[c]));
        rowd[c] <= ROW_W'(rnd_frac(rsd[c]));
      end
      if (v4) begin
        mpos[c] <= PROD_W'(rowb[c]) * PROD_W'(bu[row4]);
        mdu[c]  <= PROD_W'(rowb[c]) * PROD_W'(duw[row4]);
        mdv[c]  <= PROD_W'(rowd[c]) * PROD_W'(bu[row4]);
      end
      if (v5) begin
        acc_pos[c] <= first5 ? mpos[c] : acc_pos[c] + mpos[c];
        acc_du[c]  <= first5 ? mdu[c]  : acc_du[c] + mdu[c];
        acc_dv[c]  <= first5 ? mdv[c]  : acc_dv[c] + mdv[c];
      end
    end
  end

  always_comb begin
    cm_max = cm[0];
    if (cm[1] > cm_max) begin
      cm_max = cm[1];
    end
    if (cm[2] > cm_max) begin
      cm_max = cm[2];
    end
  end

  assign sq_try = sq_res + sq_bit;
  assign len    = sq_res[LEN_W-1:0];
  assign rem2   = {rem, nsh[Q_W-1]};

  always_comb begin
    num = {cm[cmd.lane][29:0], 16'b0} >> 2;
    num = num + NUM_W'(len >> 1);
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      for (int c = 0; c < NUM_AXES; c++) begin
        pos_r[c] <= sat_coord(rnd_frac(acc_pos[c]));
        du[c]    <= DER_W'(rnd_frac(acc_du[c]));
        dv[c]    <= DER_W'(rnd_frac(acc_dv[c]));
      end
    end
    if (cmd.rmax) begin
      kdu <= shift_k(du[0], du[1], du[2]);
      kdv <= shift_k(dv[0], dv[1], dv[2]);
    end
    if (cmd.rshift) begin
      for (int c = 0; c < NUM_AXES; c++) begin
        dur[c] <= rsh(du[c], kdu);
        dvr[c] <= rsh(dv[c], kdv);
      end
    end
    if (cmd.xmul) begin
      xp[0] <= PROD_W'(dvr[1]) * PROD_W'(dur[2]);
      xp[1] <= PROD_W'(dvr[2]) * PROD_W'(dur[1]);
      xp[2] <= PROD_W'(dvr[2]) * PROD_W'(dur[0]);
      xp[3] <= PROD_W'(dvr[0]) * PROD_W'(dur[2]);
      xp[4] <= PROD_W'(dvr[0]) * PROD_W'(dur[1]);
      xp[5] <= PROD_W'(dvr[1]) * PROD_W'(dur[0]);
    end
    if (cmd.xsub) begin
      cr[0] <= xp[0] - xp[1];
      cr[1] <= xp[2] - xp[3];
      cr[2] <= xp[4] - xp[5];
    end
    if (cmd.ninit) begin
      for (int c = 0; c < NUM_AXES; c++) begin
        cm[c]  <= cr[c][PROD_W-1] ? CM_W'(-cr[c]) : CM_W'(cr[c]);
        neg[c] <= cr[c][PROD_W-1];
      end
      degen <= (cr[0] == '0) && (cr[1] == '0) && (cr[2] == '0);
    end
    // Scale so the largest magnitude lands in [2^29, 2^30); a step of eight
    // is taken only while more than eight single steps remain.
    if (cmd.nstep) begin
      for (int c = 0; c < NUM_AXES; c++) begin
        if (cm_max >= M38) begin
          cm[c] <= cm[c] >> 8;
        end else if (cm_max >= M30) begin
          cm[c] <= cm[c] >> 1;
        end else if (cm_max < M21) begin
          cm[c] <= cm[c] << 8;
        end else if (cm_max < M29) begin
          cm[c] <= cm[c] << 1;
        end
      end
    end
    if (cmd.sq) begin
      for (int c = 0; c < NUM_AXES; c++) begin
        sq[c] <= SQ_W'(cm[c][29:0]) * SQ_W'(cm[c][29:0]);
      end
    end
    if (cmd.sqrt_init) begin
      sq_n   <= PROD_W'(sq[0]) + PROD_W'(sq[1]) + PROD_W'(sq[2]);
      sq_res <= '0;
      sq_bit <= PROD_W'(1) << 62;
    end
    if (cmd.sqrt_step) begin
      if (sq_n >= sq_try) begin
        sq_n   <= sq_n - sq_try;
        sq_res <= (sq_res >> 1) + sq_bit;
      end else begin
        sq_res <= sq_res >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
    if (cmd.div_init) begin
      rem <= LEN_W'(num >> Q_W);
      nsh <= num[Q_W-1:0];
      quo <= '0;
    end
    if (cmd.div_step) begin
      if (rem2 >= {1'b0, len}) begin
        rem <= LEN_W'(rem2 - {1'b0, len});
        quo <= {quo[Q_W-2:0], 1'b1};
      end else begin
        rem <= rem2[LEN_W-1:0];
        quo <= {quo[Q_W-2:0], 1'b0};
      end
      nsh <= nsh << 1;
    end
    if (cmd.div_store) begin
      nrm[cmd.lane] <= neg[cmd.lane] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    end
    if (cmd.out_load) begin
      result.pos_x      <= pos_r[0];
      result.pos_y      <= pos_r[1];
      result.pos_z      <= pos_r[2];
      result.norm_x     <= degen ? '0 : nrm[0];
      result.norm_y     <= degen ? '0 : nrm[1];
      result.norm_z     <= degen ? '0 : nrm[2];
      result.degenerate <= degen;
    end
  end

  assign st.acc_done   = acc_done;
  assign st.degenerate = degen;
  assign st.norm_done  = (cm_max >= M29) && (cm_max < M30);

endmodule

// ===== hw/rtl/bbpe_ctrl.sv =====
// Controller state machine that sequences the evaluator datapath.
`include "bicubic_bezier_point_evaluator_assert.svh"
module bbpe_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              op,
  output logic              item_stall,
  output logic              result_valid,
  input  logic              result_stall,
  input  bbpe_pkg::status_t st,
  output bbpe_pkg::cmd_t    cmd
);
  import bbpe_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_WGT, S_ACC, S_DRAIN, S_FIN, S_RMAX, S_RSHIFT, S_XMUL, S_XSUB,
    S_NINIT, S_NSTEP, S_SQ, S_SUM, S_SQRT, S_DINIT, S_DSTEP, S_DSTORE, S_OUT
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  logic [1:0]       lane;
  logic             accept;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;

  always_comb begin
    cmd         = '0;
    cmd.rd_addr = cnt[IDX_W-1:0];
    cmd.lane    = lane;
    case (state)
      S_IDLE: begin
        cmd.wr      = accept && (op == OP_LOAD);
        cmd.capture = accept && (op == OP_EVAL);
      end
      S_ACC:    cmd.rd = 1'b1;
      S_FIN:    cmd.fin = 1'b1;
      S_RMAX:   cmd.rmax = 1'b1;
      S_RSHIFT: cmd.rshift = 1'b1;
      S_XMUL:   cmd.xmul = 1'b1;
      S_XSUB:   cmd.xsub = 1'b1;
      S_NINIT:  cmd.ninit = 1'b1;
      S_NSTEP:  cmd.nstep = !st.norm_done && !st.degenerate;
      S_SQ:     cmd.sq = 1'b1;
      S_SUM:    cmd.sqrt_init = 1'b1;
      S_SQRT:   cmd.sqrt_step = 1'b1;
      S_DINIT:  cmd.div_init = 1'b1;
      S_DSTEP:  cmd.div_step = 1'b1;
      S_DSTORE: cmd.div_store = 1'b1;
      S_OUT:    cmd.out_load = !result_valid || !result_stall;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      lane         <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (cmd.capture) begin
            state <= S_WGT;
            cnt   <= '0;
          end
        end
        S_WGT: begin
          if (cnt == CNT_W'(WGT_CYC - 1)) begin
            state <= S_ACC;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_ACC: begin
          if (cnt == CNT_W'(NUM_CP - 1)) begin
            state <= S_DRAIN;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DRAIN: begin
          if (st.acc_done) begin
            state <= S_FIN;
          end
        end
        S_FIN:    state <= S_RMAX;
        S_RMAX:   state <= S_RSHIFT;
        S_RSHIFT: state <= S_XMUL;
        S_XMUL:   state <= S_XSUB;
        S_XSUB:   state <= S_NINIT;
        S_NINIT:  state <= S_NSTEP;
        S_NSTEP: begin
          if (st.degenerate) begin
            state <= S_OUT;
          end else if (st.norm_done) begin
            state <= S_SQ;
          end
        end
        S_SQ:  state <= S_SUM;
        S_SUM: begin
          state <= S_SQRT;
          cnt   <= '0;
        end
        S_SQRT: begin
          if (cnt == CNT_W'(SQRT_STEPS - 1)) begin
            state <= S_DINIT;
            cnt   <= '0;
            lane  <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DINIT: begin
          state <= S_DSTEP;
          cnt   <= '0;
        end
        S_DSTEP: begin
          if (cnt == CNT_W'(DIV_STEPS - 1)) begin
            state <= S_DSTORE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DSTORE: begin
          if (lane == 2'(NUM_AXES - 1)) begin
            state <= S_OUT;
          end else begin
            lane  <= lane + 1'b1;
            state <= S_DINIT;
          end
        end
        S_OUT: begin
          if (cmd.out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A new result never overwrites one that is still held by the consumer.
  `BBPE_ASSERT_SAME(a_out_free, clk, rst, cmd.out_load, !(result_valid && result_stall))
  // The accumulation pipeline only finishes while the controller waits for it.
  `BBPE_ASSERT_SAME(a_acc_in_drain, clk, rst, st.acc_done, state == S_DRAIN)
  // A zero cross product must bypass the square root.
  `BBPE_ASSERT_SAME(a_no_sqrt_degen, clk, rst, state == S_SQRT, !st.degenerate)
  // An evaluate transaction always starts the weight phase.
  `BBPE_ASSERT_NEXT(a_eval_start, clk, rst, cmd.capture, state == S_WGT)

endmodule

// ===== hw/rtl/bicubic_bezier_point_evaluator.sv =====
// Top level of the bicubic Bezier patch point evaluator.
// A load transaction writes one control point into the store.
// An evaluate transaction first forms the weights, then reads the sixteen
// control points from the store one point per cycle into the
// multiply-accumulate pipeline. That pipeline drains, and the sums are then
// rounded, the derivatives reduced and the cross product formed. The normal is
// scaled, squared and summed, and the vector length comes from a 32-step square
// root. One shared divider then takes 15 steps for each of the three normal
// components, and the result is loaded into the output register. When the cross
// product is zero, the squaring, the root and the divider are skipped. The next
// transaction is taken once the current evaluation has moved its result into
// the output register, even while that result still waits to be taken.
module bicubic_bezier_point_evaluator (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  bbpe_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output bbpe_pkg::result_t result
);
  import bbpe_pkg::*;

  cmd_t    cmd;
  status_t st;

  bbpe_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .op           (item.op),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .st           (st),
    .cmd          (cmd)
  );

  bbpe_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .st     (st),
    .result (result)
  );

endmodule
